FILE: design/cbag_pkg.sv
// ---------------------------------------------------------------------------
// cbag_pkg: shared types and constants of the bus address generator
// Cycle kinds, access kinds and the registered form of one transaction.
// ---------------------------------------------------------------------------
`default_nettype none

package cbag_pkg;

  localparam int unsigned ModeWidth = 5;
  localparam int unsigned AddrWidth = 24;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;

  typedef enum logic [ModeWidth-1:0] {
    MODE_FETCH       = 5'd0,
    MODE_PULL        = 5'd1,
    MODE_PUSH        = 5'd2,
    MODE_PULL_NATIVE = 5'd3,
    MODE_PUSH_NATIVE = 5'd4,
    MODE_RD_DP       = 5'd5,
    MODE_WR_DP       = 5'd6,
    MODE_RD_DP_NAT   = 5'd7,
    MODE_RD_BANK     = 5'd8,
    MODE_WR_BANK     = 5'd9,
    MODE_RD_LONG     = 5'd10,
    MODE_WR_LONG     = 5'd11,
    MODE_RD_STACK    = 5'd12,
    MODE_WR_STACK    = 5'd13,
    MODE_IDLE_IRQ    = 5'd14,
    MODE_IDLE2       = 5'd15,
    MODE_IDLE4       = 5'd16,
    MODE_IDLE6       = 5'd17
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_IDLE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic [AddrWidth-1:0] offset_a;
    logic [WordWidth-1:0] offset_b;
    logic [ByteWidth-1:0] prog_bank;
    logic [WordWidth-1:0] prog_word;
    logic [WordWidth-1:0] stack_ptr;
    logic [WordWidth-1:0] direct_page;
    logic [ByteWidth-1:0] data_bank;
    logic                 emulation;
    logic                 index_narrow;
    logic                 irq_pending;
    logic [ByteWidth-1:0] write_byte;
  } item_t;

endpackage

`default_nettype wire

FILE: design/cpu_bus_address_generator.sv
// ---------------------------------------------------------------------------
// cpu_bus_address_generator: bus-cycle address unit
// Forms kind, address, write data, next PC word and next stack pointer for
// one bus cycle of a 16-bit CPU with 24-bit addressing.
// ---------------------------------------------------------------------------
// Usage:
//   Drive the cycle kind (mode) and the CPU register copies with start high;
//   a transaction is taken at every rising edge where start is high and busy
//   is low. busy never rises, so a transaction may be offered every cycle.
//   The transaction is captured in an input register, the address logic
//   works on that register, and the result is loaded into the output
//   register. done rises at the edge after the one that took the
//   transaction and is high for exactly one cycle, with access_kind,
//   bus_address, bus_data, next_prog_word and next_stack_ptr valid in that
//   cycle. Throughput is one transaction per clock; each transaction passes
//   through the input register and then the result register.
//   The receiver cannot stall: each result is shown for one cycle only.
//   Synchronous reset clears both valid flags, so no done strobe follows
//   reset; payload registers are left as they are.
// ---------------------------------------------------------------------------
`default_nettype none

module cpu_bus_address_generator (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [4:0]  mode,
  input  wire  logic [23:0] offset_a,
  input  wire  logic [15:0] offset_b,
  input  wire  logic [7:0]  prog_bank,
  input  wire  logic [15:0] prog_word,
  input  wire  logic [15:0] stack_ptr,
  input  wire  logic [15:0] direct_page,
  input  wire  logic [7:0]  data_bank,
  input  wire  logic        emulation,
  input  wire  logic        index_narrow,
  input  wire  logic        irq_pending,
  input  wire  logic [7:0]  write_byte,
  output logic              done,
  output logic [1:0]        access_kind,
  output logic [23:0]       bus_address,
  output logic [7:0]        bus_data,
  output logic [15:0]       next_prog_word,
  output logic [15:0]       next_stack_ptr
);

  import cbag_pkg::*;

  item_t                item;
  logic                 item_valid;

  kind_t                kind_next;
  logic [AddrWidth-1:0] address_next;
  logic [ByteWidth-1:0] data_next;
  logic [WordWidth-1:0] pc_next;
  logic [WordWidth-1:0] sp_next;

  logic [WordWidth-1:0] sp_inc;
  logic [WordWidth-1:0] sp_dec;
  logic [WordWidth-1:0] dp_addr;
  logic [WordWidth-1:0] dp_sum;
  logic [AddrWidth-1:0] bank_addr;
  logic [WordWidth-1:0] stack_rel;
  logic [AddrWidth-1:0] pc_addr;
  logic                 emu_dp_wrap;

  // Every stage takes one transaction per cycle, so the unit is never busy
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= '{mode: mode, offset_a: offset_a, offset_b: offset_b,
                prog_bank: prog_bank, prog_word: prog_word,
                stack_ptr: stack_ptr, direct_page: direct_page,
                data_bank: data_bank, emulation: emulation,
                index_narrow: index_narrow, irq_pending: irq_pending,
                write_byte: write_byte};
    end
  end

  assign sp_inc      = item.stack_ptr + 16'd1;
  assign sp_dec      = item.stack_ptr - 16'd1;
  assign dp_sum      = item.direct_page + item.offset_a[15:0];
  assign emu_dp_wrap = item.emulation && (item.direct_page[7:0] == 8'h00);
  // In emulation with a page-aligned direct register, stay inside the page
  assign dp_addr     = emu_dp_wrap ? {item.direct_page[15:8], item.offset_a[7:0]} : dp_sum;
  assign bank_addr   = {item.data_bank, 16'h0000} + item.offset_a;
  assign stack_rel   = item.stack_ptr + item.offset_a[15:0];
  assign pc_addr     = {item.prog_bank, item.prog_word};

  always_comb begin
    kind_next    = KIND_NONE;
    address_next = '0;
    data_next    = '0;
    pc_next      = item.prog_word;
    sp_next      = item.stack_ptr;
    unique case (item.mode)
      MODE_FETCH: begin
        kind_next    = KIND_READ;
        address_next = pc_addr;
        pc_next      = item.prog_word + 16'd1;
      end
      MODE_PULL: begin
        // Emulation keeps the stack in its page: the stack pointer's high byte stays
        sp_next      = item.emulation ? {item.stack_ptr[15:8], sp_inc[7:0]} : sp_inc;
        kind_next    = KIND_READ;
        address_next = {8'h00, sp_next};
      end
      MODE_PUSH: begin
        kind_next    = KIND_WRITE;
        address_next = {8'h00, item.stack_ptr};
        data_next    = item.write_byte;
        sp_next      = item.emulation ? {item.stack_ptr[15:8], sp_dec[7:0]} : sp_dec;
      end
      MODE_PULL_NATIVE: begin
        sp_next      = sp_inc;
        kind_next    = KIND_READ;
        address_next = {8'h00, sp_inc};
      end
      MODE_PUSH_NATIVE: begin
        kind_next    = KIND_WRITE;
        address_next = {8'h00, item.stack_ptr};
        data_next    = item.write_byte;
        sp_next      = sp_dec;
      end
      MODE_RD_DP: begin
        kind_next    = KIND_READ;
        address_next = {8'h00, dp_addr};
      end
      MODE_WR_DP: begin
        kind_next    = KIND_WRITE;
        address_next = {8'h00, dp_addr};
        data_next    = item.write_byte;
      end
      MODE_RD_DP_NAT: begin
        kind_next    = KIND_READ;
        address_next = {8'h00, dp_sum};
      end
      MODE_RD_BANK: begin
        kind_next    = KIND_READ;
        address_next = bank_addr;
      end
      MODE_WR_BANK: begin
        kind_next    = KIND_WRITE;
        address_next = bank_addr;
        data_next    = item.write_byte;
      end
      MODE_RD_LONG: begin
        kind_next    = KIND_READ;
        address_next = item.offset_a;
      end
      MODE_WR_LONG: begin
        kind_next    = KIND_WRITE;
        address_next = item.offset_a;
        data_next    = item.write_byte;
      end
      MODE_RD_STACK: begin
        kind_next    = KIND_READ;
        address_next = {8'h00, stack_rel};
      end
      MODE_WR_STACK: begin
        kind_next    = KIND_WRITE;
        address_next = {8'h00, stack_rel};
        data_next    = item.write_byte;
      end
      MODE_IDLE_IRQ: begin
        // A pending interrupt turns the idle into a PC read without advance
        if (item.irq_pending) begin
          kind_next    = KIND_READ;
          address_next = pc_addr;
        end else begin
          kind_next = KIND_IDLE;
        end
      end
      MODE_IDLE2: begin
        if (item.direct_page[7:0] != 8'h00) begin
          kind_next = KIND_IDLE;
        end
      end
      MODE_IDLE4: begin
        if (!item.index_narrow || (item.offset_a[15:8] != item.offset_b[15:8])) begin
          kind_next = KIND_IDLE;
        end
      end
      MODE_IDLE6: begin
        if (item.emulation && (item.prog_word[15:8] != item.offset_a[15:8])) begin
          kind_next = KIND_IDLE;
        end
      end
      default: begin
        kind_next = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      access_kind    <= kind_next;
      bus_address    <= address_next;
      bus_data       <= data_next;
      next_prog_word <= pc_next;
      next_stack_ptr <= sp_next;
    end
  end

endmodule

`default_nettype wire
